/* hw/rtl/dtc_pkg.sv */
`default_nettype none

package dtc_pkg;

    localparam int KEY_INDEX_BITS = 24;
    localparam int BYTE_W         = 8;
    localparam int BYTE_SHIFT     = 16;
    localparam int WIN_W          = 2 * BYTE_W;
    localparam int KEY_W          = 40;
    localparam int CNT_W          = 25;

    // one bitmap row holds every third byte value for a fixed leading pair
    localparam int ROW_BITS = 2 ** BYTE_W;
    localparam int ROW_AW   = KEY_INDEX_BITS - BYTE_W;
    localparam int ROWS     = 2 ** ROW_AW;

    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(20000);
    localparam logic [CNT_W-1:0] CNT_MAX     = '1;

    typedef struct packed {
        logic load;   // take the input word
        logic clr;    // write one zero row of the sweep
        logic rd;     // read the bitmap row of the current window
        logic step;   // update state and fill the output register
    } t_dp_cmd;

    typedef struct packed {
        logic count_nz;
        logic clr_last;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

/* hw/rtl/distinct_trigram_collector_top.sv */
// Distinct trigram collector.
// Input channel (i_valid/o_ready): one word per byte of a file, with file start
// and file end marks. Output channel (o_valid/i_ready): one result word per input
// word: the trigram key ending at that byte, whether it is new, the running
// distinct count, the file end mark and the overflow flag.
// Config channel (i_cfg_valid/o_cfg_ready): writes the distinct limit; always ready.
// Each byte goes through accept, bitmap row read, and check and update; the next
// byte waits for that read-modify-write of the single-port-read bitmap RAM.
// The result word is registered by the check and update step, after the row read.
// Reset: the bitmap (65536 rows of 256 bits) is swept to zero, with o_ready low;
// config writes are still taken. A file start after a file that counted any
// trigram runs the same sweep before that byte.
// Receiver stall: the result word holds in the output register; one more byte
// is accepted and then processing holds until the register frees up.
`default_nettype none

module distinct_trigram_collector_top
    import dtc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    input  wire logic              i_file_start,
    input  wire logic              i_file_end,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CNT_W-1:0]  i_cfg_data,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic      [KEY_W-1:0]  o_trigram_key,
    output logic                   o_key_valid,
    output logic                   o_is_new,
    output logic      [CNT_W-1:0]  o_distinct_count,
    output logic                   o_file_done,
    output logic                   o_overflowed
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // limit register takes a word any cycle
    assign o_cfg_ready = 1'b1;

    dtc_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_file_start(i_file_start),
        .o_in_ready  (o_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    dtc_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_data_byte     (i_data_byte),
        .i_file_start    (i_file_start),
        .i_file_end      (i_file_end),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (i_ready),
        .o_out_valid     (o_valid),
        .o_trigram_key   (o_trigram_key),
        .o_key_valid     (o_key_valid),
        .o_is_new        (o_is_new),
        .o_distinct_count(o_distinct_count),
        .o_file_done     (o_file_done),
        .o_overflowed    (o_overflowed)
    );

endmodule

`default_nettype wire

/* hw/rtl/dtc_ram.sv */
`default_nettype none

module dtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hw/rtl/dtc_controller.sv */
`default_nettype none

module dtc_controller
    import dtc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_file_start,
    output logic            o_in_ready,
    output t_dp_cmd         o_cmd,
    input  wire t_dp_status i_status
);

    typedef enum logic [2:0] {
        S_BOOT_CLR,
        S_FILE_CLR,
        S_IDLE,
        S_READ,
        S_CHECK
    } t_state;

    t_state r_state;

    always_comb begin
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_BOOT_CLR, S_FILE_CLR: o_cmd.clr  = 1'b1;
            S_IDLE:                 o_cmd.load = i_in_valid;
            S_READ:                 o_cmd.rd   = 1'b1;
            S_CHECK:                o_cmd.step = i_status.out_free;
            default:                o_cmd      = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_BOOT_CLR;
        end else begin
            unique case (r_state)
                S_BOOT_CLR: begin
                    if (i_status.clr_last) r_state <= S_IDLE;
                end
                S_FILE_CLR: begin
                    if (i_status.clr_last) r_state <= S_READ;
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        // a new file after one with trigrams wipes the bitmap first
                        r_state <= (i_file_start && i_status.count_nz) ? S_FILE_CLR : S_READ;
                    end
                end
                S_READ: r_state <= S_CHECK;
                S_CHECK: begin
                    if (i_status.out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_BOOT_CLR;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/dtc_datapath.sv */
`default_nettype none

module dtc_datapath
    import dtc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_status             o_status,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    input  wire logic              i_file_start,
    input  wire logic              i_file_end,
    input  wire logic              i_cfg_we,
    input  wire logic [CNT_W-1:0]  i_cfg_data,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic      [KEY_W-1:0]  o_trigram_key,
    output logic                   o_key_valid,
    output logic                   o_is_new,
    output logic      [CNT_W-1:0]  o_distinct_count,
    output logic                   o_file_done,
    output logic                   o_overflowed
);

    logic [CNT_W-1:0]  r_limit;
    logic [BYTE_W-1:0] r_byte;
    logic              r_end;
    logic [WIN_W-1:0]  r_win;
    logic [1:0]        r_fill;
    logic [CNT_W-1:0]  r_count;
    logic              r_abandoned;
    logic [ROW_AW-1:0] r_clr_addr;

    logic              r_out_valid;
    logic [KEY_W-1:0]  r_out_key;
    logic              r_out_kv;
    logic              r_out_new;
    logic [CNT_W-1:0]  r_out_cnt;
    logic              r_out_done;
    logic              r_out_ovf;

    logic [ROW_BITS-1:0] rdata;
    logic [ROW_BITS-1:0] bit_mask;
    logic                look;
    logic                fresh;
    logic [CNT_W-1:0]    count_inc;
    logic [CNT_W-1:0]    n_count;
    logic                n_abandoned;
    logic [KEY_W-1:0]    key;
    logic                ram_we;
    logic [ROW_AW-1:0]   ram_waddr;
    logic [ROW_BITS-1:0] ram_wdata;

    // window row = leading byte pair, bit within the row = newest byte
    assign look      = !r_abandoned && r_fill[1];
    assign bit_mask  = ROW_BITS'(1) << r_byte;
    assign fresh     = look && !rdata[r_byte];
    assign count_inc = (r_count != CNT_MAX) ? r_count + CNT_W'(1) : r_count;
    assign n_count   = fresh ? count_inc : r_count;
    assign n_abandoned = r_abandoned || (fresh && (count_inc > r_limit));
    assign key = look ? {r_win[WIN_W-1:BYTE_W], (BYTE_SHIFT - BYTE_W)'(0),
                         r_win[BYTE_W-1:0], (BYTE_SHIFT - BYTE_W)'(0), r_byte}
                      : '0;

    assign ram_we    = i_cmd.clr || (i_cmd.step && fresh);
    assign ram_waddr = i_cmd.clr ? r_clr_addr : ROW_AW'(r_win);
    assign ram_wdata = i_cmd.clr ? '0 : (rdata | bit_mask);

    dtc_ram #(
        .WIDTH(ROW_BITS),
        .DEPTH(ROWS)
    ) u_bitmap (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (i_cmd.rd),
        .i_raddr(ROW_AW'(r_win)),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LIMIT_RESET;
            r_win       <= '0;
            r_fill      <= '0;
            r_count     <= '0;
            r_abandoned <= 1'b0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_data;

            if (i_cmd.clr) r_clr_addr <= r_clr_addr + ROW_AW'(1);

            if (i_cmd.load) begin
                r_byte <= i_data_byte;
                r_end  <= i_file_end;
                if (i_file_start) begin
                    r_win       <= '0;
                    r_fill      <= '0;
                    r_count     <= '0;
                    r_abandoned <= 1'b0;
                end
            end

            if (i_cmd.step) begin
                // an abandoned file freezes the window
                if (!r_abandoned) begin
                    r_win <= {r_win[BYTE_W-1:0], r_byte};
                    if (!look) r_fill <= r_fill + 2'd1;
                end
                r_count     <= n_count;
                r_abandoned <= n_abandoned;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_out_key  <= key;
            r_out_kv   <= look;
            r_out_new  <= fresh;
            r_out_cnt  <= n_count;
            r_out_done <= r_end;
            r_out_ovf  <= n_abandoned;
        end
    end

    assign o_status.count_nz = (r_count != '0);
    assign o_status.clr_last = &r_clr_addr;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_trigram_key    = r_out_key;
    assign o_key_valid      = r_out_kv;
    assign o_is_new         = r_out_new;
    assign o_distinct_count = r_out_cnt;
    assign o_file_done      = r_out_done;
    assign o_overflowed     = r_out_ovf;

endmodule

`default_nettype wire

/* hw/rtl/dtc_checker.sv */
`default_nettype none

module dtc_checker
    import dtc_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_ready,
    input wire logic              o_valid,
    input wire logic              i_ready,
    input wire logic [KEY_W-1:0]  o_trigram_key,
    input wire logic              o_key_valid,
    input wire logic              o_is_new,
    input wire logic [CNT_W-1:0]  o_distinct_count
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_trigram_key)
                                && $stable(o_distinct_count))
        else $error("stalled result word changed");

    // drop key and new flag on a result without a full window
    a_no_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_key_valid |-> !o_is_new && (o_trigram_key == '0))
        else $error("key or new flag without a full window");

    // the gaps between the packed bytes stay zero
    a_key_gaps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_trigram_key[31:24] == '0) && (o_trigram_key[15:8] == '0))
        else $error("trigram key gap bits set");

    // a new trigram counts at least one
    a_new_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_new |-> (o_distinct_count != '0))
        else $error("new trigram with zero count");

    // the bitmap sweep after reset blocks input
    a_boot_sweep: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_ready)
        else $error("input ready during bitmap sweep");

endmodule

bind distinct_trigram_collector_top dtc_checker u_dtc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_trigram_key   (o_trigram_key),
    .o_key_valid     (o_key_valid),
    .o_is_new        (o_is_new),
    .o_distinct_count(o_distinct_count)
);

`default_nettype wire

/* test/distinct_trigram_collector_top_test.sv */
`timescale 1ns / 1ps

module distinct_trigram_collector_top_test;
    import dtc_pkg::*;

    // Total run limit, in clock cycles. Reset and every file start after a
    // file that counted trigrams sweep the whole bitmap. About 20 of those
    // occur, so the limit leaves ample margin over the slowest correct run.
    localparam int unsigned CYC_LIMIT   = 6_000_000;
    localparam int unsigned LIVE_TARGET = 1350;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned TAIL_CYCLES = 20;
    localparam int unsigned ERR_PRINTS  = 40;
    localparam logic [CNT_W-1:0] LIMIT_TOP = CNT_W'(25'h100_0000);

    // One result word as the block reports it.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             key_ok;
        logic             fresh;
        logic [CNT_W-1:0] count;
        logic             done;
        logic             over;
    } t_trigram_word;

    typedef enum bit {ROW_WORD, ROW_LIMIT} t_row_kind;

    // One directed row: either a byte word, or a write of the limit.
    // When typed is set, want holds the expected result word.
    typedef struct packed {
        t_row_kind        kind;
        logic [BYTE_W-1:0] data;
        logic             first;
        logic             fin;
        logic             typed;
        t_trigram_word    want;
        logic [CNT_W-1:0] limit;
    } t_stim_row;

    localparam int DIR_N = 29;

    localparam t_stim_row DIR_ROWS [DIR_N] = '{
        // file with extreme bytes; the window wraps back onto a known trigram
        '{ROW_WORD, 8'h00, 1'b1, 1'b0, 1'b1, '0, '0},
        '{ROW_WORD, 8'hFF, 1'b0, 1'b0, 1'b1, '0, '0},
        '{ROW_WORD, 8'h80, 1'b0, 1'b0, 1'b1,
          '{40'h00_00FF_0080, 1'b1, 1'b1, 25'd1, 1'b0, 1'b0}, '0},
        '{ROW_WORD, 8'h00, 1'b0, 1'b0, 1'b1,
          '{40'hFF_0080_0000, 1'b1, 1'b1, 25'd2, 1'b0, 1'b0}, '0},
        '{ROW_WORD, 8'hFF, 1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_WORD, 8'h80, 1'b0, 1'b1, 1'b0, '0, '0},
        // byte after the end mark with no start: same file goes on
        '{ROW_WORD, 8'hFF, 1'b0, 1'b0, 1'b0, '0, '0},
        // one-byte file, then a two-byte file: no key ever forms
        '{ROW_WORD, 8'h55, 1'b1, 1'b1, 1'b1,
          '{40'h0, 1'b0, 1'b0, 25'd0, 1'b1, 1'b0}, '0},
        '{ROW_WORD, 8'hAA, 1'b1, 1'b0, 1'b0, '0, '0},
        '{ROW_WORD, 8'h11, 1'b0, 1'b1, 1'b0, '0, '0},
        // constant bytes: the same trigram repeats and is not new
        '{ROW_WORD, 8'hFF, 1'b1, 1'b0, 1'b0, '0, '0},
        '{ROW_WORD, 8'hFF, 1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_WORD, 8'hFF, 1'b0, 1'b0, 1'b1,
          '{40'hFF_00FF_00FF, 1'b1, 1'b1, 25'd1, 1'b0, 1'b0}, '0},
        '{ROW_WORD, 8'hFF, 1'b0, 1'b1, 1'b0, '0, '0},
        // limit of one: second distinct trigram overflows, the rest is dropped
        '{ROW_LIMIT, 8'h00, 1'b0, 1'b0, 1'b0, '0, 25'd1},
        '{ROW_WORD, 8'h01, 1'b1, 1'b0, 1'b0, '0, '0},
        '{ROW_WORD, 8'h02, 1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_WORD, 8'h03, 1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_WORD, 8'h04, 1'b0, 1'b0, 1'b1,
          '{40'h02_0003_0004, 1'b1, 1'b1, 25'd2, 1'b0, 1'b1}, '0},
        '{ROW_WORD, 8'h05, 1'b0, 1'b0, 1'b1,
          '{40'h0, 1'b0, 1'b0, 25'd2, 1'b0, 1'b1}, '0},
        '{ROW_WORD, 8'h06, 1'b0, 1'b1, 1'b0, '0, '0},
        // zero limit: the first trigram already overflows
        '{ROW_LIMIT, 8'h00, 1'b0, 1'b0, 1'b0, '0, 25'd0},
        '{ROW_WORD, 8'h09, 1'b1, 1'b0, 1'b0, '0, '0},
        '{ROW_WORD, 8'h08, 1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_WORD, 8'h07, 1'b0, 1'b1, 1'b0, '0, '0},
        // highest limit the bench writes
        '{ROW_LIMIT, 8'h00, 1'b0, 1'b0, 1'b0, '0, LIMIT_TOP},
        '{ROW_WORD, 8'h12, 1'b1, 1'b0, 1'b0, '0, '0},
        '{ROW_WORD, 8'h34, 1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_WORD, 8'h56, 1'b0, 1'b1, 1'b0, '0, '0}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [BYTE_W-1:0] i_data_byte;
    logic              i_file_start;
    logic              i_file_end;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CNT_W-1:0]  i_cfg_data;
    logic              o_valid;
    logic              i_ready;
    logic [KEY_W-1:0]  o_trigram_key;
    logic              o_key_valid;
    logic              o_is_new;
    logic [CNT_W-1:0]  o_distinct_count;
    logic              o_file_done;
    logic              o_overflowed;

    distinct_trigram_collector_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_file_start     (i_file_start),
        .i_file_end       (i_file_end),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_trigram_key    (o_trigram_key),
        .o_key_valid      (o_key_valid),
        .o_is_new         (o_is_new),
        .o_distinct_count (o_distinct_count),
        .o_file_done      (o_file_done),
        .o_overflowed     (o_overflowed)
    );

    // Trigram set state of the predictor, mirrored from the block's behavior.
    bit                seen_map [logic [KEY_INDEX_BITS-1:0]];
    logic [2*BYTE_W-1:0] win_pair;
    int unsigned       win_fill;
    logic [CNT_W-1:0]  trigram_total;
    bit                file_dropped;
    logic [CNT_W-1:0]  cur_limit;

    // Result words still owed by the block, oldest first.
    t_trigram_word     pending_words [$];
    t_trigram_word     got_word;
    t_trigram_word     want_word;

    int unsigned cyc_count;
    int unsigned n_err;
    int unsigned n_checked;
    int unsigned n_words;
    int unsigned n_live;
    int unsigned n_files;
    int unsigned n_fresh;
    int unsigned n_over;
    int unsigned n_cfg;
    bit          tx_calm;
    bit          rx_hold;

    // Free-running clock, period 4 ns.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: end the run if the block stops making progress.
    initial cyc_count = 0;
    always @(posedge i_clk) begin
        cyc_count <= cyc_count + 1;
        if (cyc_count > CYC_LIMIT) begin
            $display("%0t: run limit of %0d cycles reached, %0d words still owed",
                     $time, CYC_LIMIT, pending_words.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Predict the result word for one accepted byte word and advance the state.
    function automatic t_trigram_word slide_window(input logic [BYTE_W-1:0] b,
                                                   input logic first,
                                                   input logic fin);
        t_trigram_word            r;
        logic [KEY_INDEX_BITS-1:0] idx;
        r = '0;
        // Clear the set on a file start; skip the wipe when nothing was counted.
        if (first) begin
            if (trigram_total != 0)
                seen_map.delete();
            win_pair      = '0;
            win_fill      = 0;
            trigram_total = '0;
            file_dropped  = 1'b0;
        end
        // An abandoned file freezes everything: the window does not move.
        if (!file_dropped) begin
            if (win_fill >= 2) begin
                idx      = {win_pair, b};
                r.key    = {win_pair[15:8], 8'h00, win_pair[7:0], 8'h00, b};
                r.key_ok = 1'b1;
                if (!seen_map.exists(idx)) begin
                    seen_map[idx] = 1'b1;
                    r.fresh       = 1'b1;
                    if (trigram_total != CNT_MAX)
                        trigram_total = trigram_total + 1'b1;
                    if (trigram_total > cur_limit)
                        file_dropped = 1'b1;
                end
            end else begin
                win_fill++;
            end
            win_pair = {win_pair[7:0], b};
        end
        r.count = trigram_total;
        r.done  = fin;
        r.over  = file_dropped;
        return r;
    endfunction

    // Sender gap before a word: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CNT_W-1:0] pick_limit();
        case ($urandom_range(0, 4))
            0, 1:    return LIMIT_TOP;
            2:       return LIMIT_RESET;
            3:       return CNT_W'($urandom_range(1, 32'h100_0000));
            default: return CNT_W'($urandom_range(1, 40));
        endcase
    endfunction

    function automatic void flag(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            if (n_err < ERR_PRINTS)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            n_err++;
        end
    endfunction

    // Offer one byte word; hold it until accepted, then queue its prediction.
    // Start and finish at a falling edge.
    task automatic send_word(input logic [BYTE_W-1:0] b, input logic first,
                             input logic fin, input logic typed,
                             input t_trigram_word typed_want);
        int            gap;
        bit            live;
        t_trigram_word r;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_data_byte  <= b;
        i_file_start <= first;
        i_file_end   <= fin;
        do @(posedge i_clk); while (!o_ready);
        live = first || !file_dropped;
        r    = slide_window(b, first, fin);
        if (typed)
            r = typed_want;
        pending_words.push_back(r);
        n_words++;
        if (live)
            n_live++;
        if (first)
            n_files++;
        if (r.fresh)
            n_fresh++;
        if (r.fresh && r.over)
            n_over++;
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every owed word has come out.
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(negedge i_clk);
        repeat (5) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [CNT_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        cur_limit = v;
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // One file with random content. The byte source varies per
    // file: full range, a tiny alphabet that repeats trigrams, or extremes.
    task automatic play_file();
        int          len;
        int          mode;
        bit          closes;
        logic        fin;
        logic [BYTE_W-1:0] b;
        len     = ($urandom_range(0, 9) == 0) ? $urandom_range(300, 400)
                                              : $urandom_range(90, 200);
        mode    = $urandom_range(0, 3);
        closes  = ($urandom_range(0, 9) != 0);
        tx_calm = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < len; k++) begin
            case (mode)
                0, 1: b = BYTE_W'($urandom);
                2:    b = BYTE_W'($urandom_range(0, 3));
                default: begin
                    case ($urandom_range(0, 4))
                        0:       b = 8'h00;
                        1:       b = 8'hFF;
                        2:       b = 8'h80;
                        3:       b = 8'h7F;
                        default: b = 8'h01;
                    endcase
                end
            endcase
            // Sprinkle stray end marks mid-file; they must change nothing.
            fin = (k == len - 1) ? closes : ($urandom_range(0, 39) == 0);
            send_word(b, (k == 0), fin, 1'b0, '0);
        end
    endtask

    // A file too short to form any trigram.
    task automatic short_file();
        int n;
        n = $urandom_range(1, 2);
        for (int k = 0; k < n; k++)
            send_word(BYTE_W'($urandom), (k == 0),
                      (k == n - 1) && ($urandom_range(0, 3) != 0), 1'b0, '0);
    endtask

    // Result monitor: compare each accepted result word with the oldest
    // prediction, field by field.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            got_word = '{o_trigram_key, o_key_valid, o_is_new, o_distinct_count,
                         o_file_done, o_overflowed};
            if (pending_words.size() == 0) begin
                if (n_err < ERR_PRINTS)
                    $display("%0t: result word with none expected, expected nothing, got %0h",
                             $time, got_word);
                n_err++;
            end else begin
                want_word = pending_words.pop_front();
                flag("trigram_key", 64'(want_word.key), 64'(got_word.key));
                flag("key_valid", 64'(want_word.key_ok), 64'(got_word.key_ok));
                flag("is_new", 64'(want_word.fresh), 64'(got_word.fresh));
                flag("distinct_count", 64'(want_word.count), 64'(got_word.count));
                flag("file_done", 64'(want_word.done), 64'(got_word.done));
                flag("overflowed", 64'(want_word.over), 64'(got_word.over));
                n_checked++;
            end
        end
    end

    // Receiver: mostly ready, with short stalls, rare long ones, and calm
    // stretches that never stall.
    initial begin
        int r;
        int rx_stall;
        int span;
        bit rx_calm;
        i_ready  = 1'b0;
        rx_stall = 0;
        span     = 200;
        rx_calm  = 1'b0;
        forever begin
            @(negedge i_clk);
            span--;
            if (span <= 0) begin
                rx_calm = ($urandom_range(0, 3) == 0);
                span    = $urandom_range(100, 600);
            end
            if (rx_hold) begin
                i_ready <= 1'b0;
            end else if (rx_stall > 0) begin
                i_ready <= 1'b0;
                rx_stall--;
            end else if (rx_calm) begin
                i_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    rx_stall = (r == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
                    i_ready <= 1'b0;
                end else begin
                    i_ready <= 1'b1;
                end
            end
        end
    end

    // Back-pressure: once traffic is flowing, hold the receiver off for a long
    // stretch while the sender keeps offering, so the block fills and stalls.
    initial begin
        rx_hold = 1'b0;
        wait (n_checked >= 300);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    // Stimulus: reset, directed rows, then random files until enough
    // words have gone in.
    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data_byte   = '0;
        i_file_start  = 1'b0;
        i_file_end    = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        tx_calm       = 1'b0;
        win_pair      = '0;
        win_fill      = 0;
        trigram_total = '0;
        file_dropped  = 1'b0;
        cur_limit     = LIMIT_RESET;
        n_err         = 0;
        n_checked     = 0;
        n_words       = 0;
        n_live        = 0;
        n_files       = 0;
        n_fresh       = 0;
        n_over        = 0;
        n_cfg         = 0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIR_ROWS[i]) begin
            if (DIR_ROWS[i].kind == ROW_LIMIT) begin
                settle();
                write_limit(DIR_ROWS[i].limit);
            end else begin
                send_word(DIR_ROWS[i].data, DIR_ROWS[i].first, DIR_ROWS[i].fin,
                          DIR_ROWS[i].typed, DIR_ROWS[i].want);
            end
        end

        // Every word sent counts toward the target, dropped ones too.
        while (n_words < LIVE_TARGET) begin
            if ($urandom_range(0, 9) < 6) begin
                settle();
                write_limit(pick_limit());
            end
            play_file();
            if ($urandom_range(0, 1) == 1)
                short_file();
        end

        i_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("covered %0d byte words (%0d worked on) over %0d files, %0d results checked",
                 n_words, n_live, n_files, n_checked);
        $display("%0d new trigrams, %0d overflowing words, %0d limit writes, %0d errors",
                 n_fresh, n_over, n_cfg, n_err);
        if (n_err == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* distinct_trigram_collector_top.f */
hw/rtl/dtc_pkg.sv
hw/rtl/dtc_ram.sv
hw/rtl/dtc_controller.sv
hw/rtl/dtc_datapath.sv
hw/rtl/distinct_trigram_collector_top.sv
hw/rtl/dtc_checker.sv
test/distinct_trigram_collector_top_test.sv
